// ===== rtl/core/pcdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdf_pkg: shared types and the CRC function of the packet CRC duplicate filter
// Beat formats, the controller state type and the bytewise CRC-32 update.
// ----------------------------------------------------------------------------
package pcdf_pkg;

	// Default number of stored CRCs in the history ring.
	localparam int HISTORY_DEPTH_DEF = 16;

	// Reflected CRC-32 polynomial.
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	// Input opcodes.
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// One input beat.
	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_packet;
	} pcdf_in_t;

	// One result beat.
	typedef struct packed {
		logic [31:0] packet_crc;
		logic        is_unique;
		logic [3:0]  stored_slot;
	} pcdf_out_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} pcdf_state_t;

	// Folds one byte into a reflected CRC-32, one bit per step.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] v;
		v = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/pcdf_hist_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcdf_hist_ram: history store of the duplicate filter
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pcdf_hist_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; read data is registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/packet_crc_dedup_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_crc_dedup_filter: CRC-32 keyed duplicate packet filter
// Runs a reflected CRC-32 over packet bytes and checks it against a history ring.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle while no check is running and folded
// into a reflected CRC-32 that starts at zero and has no final inversion. An
// end-of-packet beat starts a check: the stored CRCs are read from the history
// memory one per cycle over its single read port, and the input is stalled
// through the scan and until the result is loaded into the output register,
// which waits while the previous result is not yet taken. The scan covers the
// valid entries, at most HISTORY_DEPTH. A CRC that matches no entry is written
// into the ring at the next slot and reported unique. A clear beat empties the
// history and leaves a packet in progress untouched. The memory needs no
// clearing pass: only entries below the fill count are ever read.
module packet_crc_dedup_filter import pcdf_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  pcdf_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output pcdf_out_t result
);

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	pcdf_state_t state_q, state_d;

	logic [31:0]      run_crc_q;
	logic [31:0]      chk_crc_q;
	logic [CNT_W-1:0] filled_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [IDX_W-1:0] wr_slot_q;
	logic             match_q;
	logic             rd_pend_s1;
	logic             result_valid_q;
	pcdf_out_t        result_q;

	logic             accept;
	logic             rd_en;
	logic             out_free;
	logic             load_result;
	logic             wr_en;
	logic [31:0]      crc_next;
	logic [31:0]      rd_data;
	logic [IDX_W+3:0] slot_wide;

	// Handshake and datapath helpers.
	assign accept      = item_valid && !item_stall;
	assign out_free    = !result_valid_q || !result_stall;
	assign rd_en       = (state_q == ST_SCAN) && (rd_cnt_q != filled_q);
	assign load_result = (state_q == ST_DONE) && out_free;
	assign wr_en       = load_result && !match_q;
	assign crc_next    = item.byte_present ? crc_byte(run_crc_q, item.data_byte) : run_crc_q;
	assign slot_wide   = {4'd0, wr_slot_q};

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// History memory.
	pcdf_hist_ram #(
		.DEPTH(HISTORY_DEPTH),
		.WIDTH(32)
	) u_hist (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_slot_q),
		.wr_data(chk_crc_q),
		.rd_en  (rd_en),
		.rd_addr(rd_cnt_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.opcode == OP_BYTE && item.end_of_packet) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!rd_en && !rd_pend_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// CRC accumulation, history control and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_crc_q  <= '0;
			filled_q   <= '0;
			wr_slot_q  <= '0;
			rd_cnt_q   <= '0;
			match_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (accept) begin
				if (item.opcode == OP_CLEAR) begin
					filled_q  <= '0;
					wr_slot_q <= '0;
				end else if (item.end_of_packet) begin
					run_crc_q <= '0;
					rd_cnt_q  <= '0;
					match_q   <= 1'b0;
				end else begin
					run_crc_q <= crc_next;
				end
			end
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			// Compare the entry read in the previous cycle.
			if (rd_pend_s1 && rd_data == chk_crc_q) begin
				match_q <= 1'b1;
			end
			// A unique CRC advances the ring.
			if (wr_en) begin
				if (wr_slot_q == IDX_W'(HISTORY_DEPTH - 1)) begin
					wr_slot_q <= '0;
				end else begin
					wr_slot_q <= wr_slot_q + 1'b1;
				end
				if (filled_q < CNT_W'(HISTORY_DEPTH)) begin
					filled_q <= filled_q + 1'b1;
				end
			end
		end
	end

	// CRC under check.
	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_BYTE && item.end_of_packet) begin
			chk_crc_q <= crc_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q.packet_crc  <= chk_crc_q;
			result_q.is_unique   <= !match_q;
			result_q.stored_slot <= match_q ? 4'd0 : slot_wide[3:0];
		end
	end

endmodule
